// File: rtl/core/rfcd_pkg.sv
// Shared types, constants and CRC helpers for the frame deframer.
package rfcd_pkg;

    // Frame length field: lengths at or above 2**LENGTH_BITS are rejected
    localparam int LENGTH_BITS = 24;
    localparam int WL_BITS     = LENGTH_BITS - 2;
    localparam int FB_BITS     = 24;
    localparam logic [FB_BITS-1:0] FB_MASK = (LENGTH_BITS >= FB_BITS) ?
        {FB_BITS{1'b1}} : FB_BITS'((64'd1 << LENGTH_BITS) - 64'd1);

    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;

    localparam logic [31:0] LEN_PAD = 32'd4;
    localparam logic [31:0] LEN_MIN = 32'd16;
    localparam logic [WL_BITS-1:0] HDR_WORDS = WL_BITS'(4);

    // Front queue depth
    localparam int FQ_DEPTH = 4;
    localparam int FQ_PTR_BITS = $clog2(FQ_DEPTH);
    localparam int FQ_CNT_BITS = $clog2(FQ_DEPTH + 1);

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_FRAME_BYTES  = 2'd0;
    localparam logic [1:0] CFG_CRC_CHECK_ENABLE = 2'd1;
    localparam logic [1:0] CFG_INITIAL_SEQUENCE = 2'd2;

    localparam logic [31:0] INIT_SEQ_RESET = 32'hFFFFFFFE;

    // Input item kinds
    localparam logic KIND_WORD    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // Result kinds
    localparam logic [1:0] OUT_BODY  = 2'd0;
    localparam logic [1:0] OUT_GOOD  = 2'd1;
    localparam logic [1:0] OUT_ERROR = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_LENGTH   = 2'd1;
    localparam logic [1:0] ERR_CRC      = 2'd2;
    localparam logic [1:0] ERR_SEQUENCE = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [31:0] word;
    } in_t;

    typedef struct packed {
        logic [1:0]         out_kind;
        logic [31:0]        body_word;
        logic [31:0]        frame_type;
        logic signed [31:0] frame_sequence;
        logic [23:0]        frame_bytes;
        logic [1:0]         fault_code;
        logic               last_body;
    } out_t;

    // Classified request held between front and back
    typedef struct packed {
        logic        kind;
        logic [31:0] word;
        logic        len_err;
        logic        len_pad;
    } item_t;

    typedef enum logic [4:0] {
        PH_LEN  = 5'b00001,
        PH_SEQ  = 5'b00010,
        PH_TYPE = 5'b00100,
        PH_BODY = 5'b01000,
        PH_CRC  = 5'b10000
    } phase_t;

    // Column of the word-wide CRC update matrix for one input bit
    function automatic logic [31:0] crc_column(input int bit_idx);
        logic [31:0] c;
        c = 32'h1 << bit_idx;
        for (int i = 0; i < 32; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/core/rfcd_front.sv
// Front end: classify incoming length words and queue requests for the back end.
module rfcd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  rfcd_pkg::in_t         item,
    input  logic [23:0]           max_frame_bytes,
    output logic                  valid,
    output rfcd_pkg::item_t       head,
    input  logic                  take
);

    rfcd_pkg::item_t                      fq_mem [rfcd_pkg::FQ_DEPTH];
    logic [rfcd_pkg::FQ_PTR_BITS-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [rfcd_pkg::FQ_PTR_BITS-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [rfcd_pkg::FQ_CNT_BITS-1:0]     count_reg, count_next;
    rfcd_pkg::item_t                      cls;
    logic                                 bad_base;
    logic                                 is_pad;
    logic                                 wr_en;
    logic                                 rd_en;

    // Length checks that depend only on the word and the limit register
    always_comb
    begin
        bad_base = (item.word == 32'd0) || item.word[31] || (item.word[1:0] != 2'd0)
                || ((max_frame_bytes != 24'd0) && (item.word > {8'd0, max_frame_bytes}))
                || (item.word[31:rfcd_pkg::LENGTH_BITS] != '0);
        is_pad   = (item.word == rfcd_pkg::LEN_PAD);
        cls.kind    = item.kind;
        cls.word    = item.word;
        cls.len_err = bad_base || (!is_pad && (item.word < rfcd_pkg::LEN_MIN));
        cls.len_pad = !bad_base && is_pad;
    end

    assign full  = (count_reg == rfcd_pkg::FQ_CNT_BITS'(rfcd_pkg::FQ_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = fq_mem[rd_ptr_reg];
    assign wr_en = push && !full;
    assign rd_en = take && valid;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fq_mem[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/rfcd_back.sv
// Back end: frame state machine, CRC, sequence check and result queue.
module rfcd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid,
    input  rfcd_pkg::item_t       head,
    output logic                  take,
    input  logic                  crc_check_enable,
    input  logic [31:0]           initial_sequence,
    output logic                  empty,
    input  logic                  pop,
    output rfcd_pkg::out_t        result
);

    rfcd_pkg::phase_t                 phase_reg, phase_next;
    logic [rfcd_pkg::WL_BITS-1:0]     words_left_reg, words_left_next;
    logic [31:0]                      crc_reg, crc_next;
    logic [31:0]                      exp_seq_reg, exp_seq_next;
    logic [23:0]                      len_reg, len_next;
    logic [31:0]                      type_reg, type_next;
    logic [31:0]                      seq_reg, seq_next;
    logic                             failed_reg, failed_next;

    rfcd_pkg::out_t                   oq_mem [2];
    logic                             oq_wr_reg, oq_rd_reg;
    logic [1:0]                       oq_cnt_reg, oq_cnt_next;
    logic                             oq_full;
    logic                             oq_pop;

    logic [31:0]                      crc_x;
    logic [31:0]                      crc_terms [32];
    logic [31:0]                      crc_upd;
    logic                             emit;
    rfcd_pkg::out_t                   res;

    // Word-wide CRC update as a constant XOR matrix
    assign crc_x = crc_reg ^ head.word;
    for (genvar g = 0; g < 32; g++)
    begin : g_col
        localparam logic [31:0] COL = rfcd_pkg::crc_column(g);
        assign crc_terms[g] = crc_x[g] ? COL : 32'd0;
    end

    always_comb
    begin
        crc_upd = 32'd0;
        for (int i = 0; i < 32; i++)
        begin
            crc_upd = crc_upd ^ crc_terms[i];
        end
    end

    assign oq_full = (oq_cnt_reg == 2'd2);
    assign take    = valid && !oq_full;
    assign empty   = (oq_cnt_reg == 2'd0);
    assign result  = oq_mem[oq_rd_reg];
    assign oq_pop  = pop && !empty;

    always_comb
    begin
        phase_next      = phase_reg;
        words_left_next = words_left_reg;
        crc_next        = crc_reg;
        exp_seq_next    = exp_seq_reg;
        len_next        = len_reg;
        type_next       = type_reg;
        seq_next        = seq_reg;
        failed_next     = failed_reg;
        emit            = 1'b0;
        res.out_kind       = rfcd_pkg::OUT_BODY;
        res.body_word      = 32'd0;
        res.frame_type     = type_reg;
        res.frame_sequence = seq_reg;
        res.frame_bytes    = len_reg;
        res.fault_code     = rfcd_pkg::ERR_NONE;
        res.last_body      = 1'b0;

        if (take)
        begin
            if (head.kind == rfcd_pkg::KIND_RESTART)
            begin
                failed_next  = 1'b0;
                exp_seq_next = initial_sequence;
                phase_next   = rfcd_pkg::PH_LEN;
                words_left_next = '0;
                crc_next     = rfcd_pkg::CRC_PRESET;
                len_next     = 24'd0;
                type_next    = 32'd0;
                seq_next     = 32'd0;
            end
            else if (!failed_reg)
            begin
                case (phase_reg)
                    rfcd_pkg::PH_LEN:
                    begin
                        if (head.len_err)
                        begin
                            emit            = 1'b1;
                            res.out_kind    = rfcd_pkg::OUT_ERROR;
                            res.fault_code  = rfcd_pkg::ERR_LENGTH;
                            res.frame_bytes = head.word[23:0] & rfcd_pkg::FB_MASK;
                            failed_next     = 1'b1;
                        end
                        else if (!head.len_pad)
                        begin
                            crc_next   = crc_upd;
                            len_next   = head.word[23:0] & rfcd_pkg::FB_MASK;
                            words_left_next = head.word[rfcd_pkg::LENGTH_BITS-1:2]
                                            - rfcd_pkg::HDR_WORDS;
                            phase_next = rfcd_pkg::PH_SEQ;
                        end
                    end
                    rfcd_pkg::PH_SEQ:
                    begin
                        seq_next   = head.word;
                        crc_next   = crc_upd;
                        phase_next = rfcd_pkg::PH_TYPE;
                    end
                    rfcd_pkg::PH_TYPE:
                    begin
                        type_next  = head.word;
                        crc_next   = crc_upd;
                        phase_next = (words_left_reg != '0) ? rfcd_pkg::PH_BODY
                                                            : rfcd_pkg::PH_CRC;
                    end
                    rfcd_pkg::PH_BODY:
                    begin
                        crc_next        = crc_upd;
                        words_left_next = words_left_reg - 1'b1;
                        emit            = 1'b1;
                        res.body_word   = head.word;
                        res.last_body   = (words_left_reg == rfcd_pkg::WL_BITS'(1));
                        if (res.last_body)
                        begin
                            phase_next = rfcd_pkg::PH_CRC;
                        end
                    end
                    rfcd_pkg::PH_CRC:
                    begin
                        emit = 1'b1;
                        if (crc_check_enable && (~crc_reg != head.word))
                        begin
                            res.out_kind   = rfcd_pkg::OUT_ERROR;
                            res.fault_code = rfcd_pkg::ERR_CRC;
                            failed_next    = 1'b1;
                        end
                        else if (seq_reg != exp_seq_reg)
                        begin
                            res.out_kind   = rfcd_pkg::OUT_ERROR;
                            res.fault_code = rfcd_pkg::ERR_SEQUENCE;
                            failed_next    = 1'b1;
                        end
                        else
                        begin
                            res.out_kind = rfcd_pkg::OUT_GOOD;
                            exp_seq_next = exp_seq_reg + 32'd1;
                        end
                        phase_next      = rfcd_pkg::PH_LEN;
                        words_left_next = '0;
                        crc_next        = rfcd_pkg::CRC_PRESET;
                        len_next        = 24'd0;
                        type_next       = 32'd0;
                        seq_next        = 32'd0;
                    end
                    default:
                    begin
                        phase_next = rfcd_pkg::PH_LEN;
                    end
                endcase
            end
        end

        oq_cnt_next = oq_cnt_reg;
        if (emit && !oq_pop)
        begin
            oq_cnt_next = oq_cnt_reg + 2'd1;
        end
        else if (oq_pop && !emit)
        begin
            oq_cnt_next = oq_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            oq_mem[oq_wr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= rfcd_pkg::PH_LEN;
            words_left_reg <= '0;
            crc_reg        <= rfcd_pkg::CRC_PRESET;
            exp_seq_reg    <= rfcd_pkg::INIT_SEQ_RESET;
            len_reg        <= 24'd0;
            type_reg       <= 32'd0;
            seq_reg        <= 32'd0;
            failed_reg     <= 1'b0;
            oq_wr_reg      <= 1'b0;
            oq_rd_reg      <= 1'b0;
            oq_cnt_reg     <= 2'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            words_left_reg <= words_left_next;
            crc_reg        <= crc_next;
            exp_seq_reg    <= exp_seq_next;
            len_reg        <= len_next;
            type_reg       <= type_next;
            seq_reg        <= seq_next;
            failed_reg     <= failed_next;
            oq_wr_reg      <= oq_wr_reg ^ emit;
            oq_rd_reg      <= oq_rd_reg ^ oq_pop;
            oq_cnt_reg     <= oq_cnt_next;
        end
    end

endmodule

// File: rtl/core/rpc_frame_crc_deframer.sv
// Top level of the length-prefixed frame deframer with CRC-32 and sequence check.
//
//   channel   handshake                 payload              direction
//   -------   -----------------------   ------------------   ---------
//   input     push / full               item   (in_t)        in
//   result    empty / pop               result (out_t)       out
//   config    cfg_write                 cfg_index, cfg_data  in
//
// One request per cycle sustained while a result slot is free: the back end runs
// the whole word step (CRC matrix update, length and sequence checks) at once.
// A request is registered in the front queue, and its result in the result
// queue, before it shows on the result ports and can be popped.
// Reset clears control state at once; there is no clearing pass.
// full rises when the four-entry front queue is occupied; the back end holds
// while both result slots wait to be popped.
module rpc_frame_crc_deframer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  rfcd_pkg::in_t    item,
    output logic             empty,
    input  logic             pop,
    output rfcd_pkg::out_t   result,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data
);

    logic [23:0]         max_frame_bytes_reg;
    logic                crc_check_enable_reg;
    logic [31:0]         initial_sequence_reg;

    logic                fq_valid;
    logic                fq_take;
    rfcd_pkg::item_t     fq_head;

    // Configuration registers: written only while the block is idle (user rule)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_bytes_reg  <= 24'd0;
            crc_check_enable_reg <= 1'b1;
            initial_sequence_reg <= rfcd_pkg::INIT_SEQ_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rfcd_pkg::CFG_MAX_FRAME_BYTES:  max_frame_bytes_reg  <= cfg_data[23:0];
                rfcd_pkg::CFG_CRC_CHECK_ENABLE: crc_check_enable_reg <= cfg_data[0];
                rfcd_pkg::CFG_INITIAL_SEQUENCE: initial_sequence_reg <= cfg_data;
                default:
                begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // Front: classify length words and queue each request
    rfcd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .item            (item),
        .max_frame_bytes (max_frame_bytes_reg),
        .valid           (fq_valid),
        .head            (fq_head),
        .take            (fq_take)
    );

    // Back: advance the frame state, check CRC and sequence, hold results
    rfcd_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .valid            (fq_valid),
        .head             (fq_head),
        .take             (fq_take),
        .crc_check_enable (crc_check_enable_reg),
        .initial_sequence (initial_sequence_reg),
        .empty            (empty),
        .pop              (pop),
        .result           (result)
    );

endmodule

// File: test/frame_checker.sv
// CRC helper package and the scoreboard checker that predicts and compares deframer results.
package frame_crc_pkg;

    // Fold one 32-bit little-endian word into a reflected CRC-32 accumulator.
    function automatic logic [31:0] crc32_fold(input logic [31:0] crc, input logic [31:0] w);
        logic [31:0] c;
        c = crc ^ w;
        for (int i = 0; i < 32; i++)
        begin
            c = c[0] ? ((c >> 1) ^ rfcd_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

module frame_checker
    import rfcd_pkg::*;
    import frame_crc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  in_t         item,
    input  logic        empty,
    input  logic        pop,
    input  out_t        result,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatches,
    output int          outstanding
);

    // Register copies
    logic [23:0]        max_bytes;
    logic               crc_on;
    logic [31:0]        init_seq;

    // Frame state
    phase_t             ph;
    logic [WL_BITS-1:0] body_left;
    logic [31:0]        crc_acc;
    logic [31:0]        seq_expected;
    logic [23:0]        cur_len;
    logic [31:0]        cur_type;
    logic [31:0]        cur_seq;
    logic               stuck;

    out_t               pending_results[$];
    int                 bad_count;

    task automatic clear_frame();
        ph        = PH_LEN;
        body_left = '0;
        crc_acc   = CRC_PRESET;
        cur_len   = '0;
        cur_type  = '0;
        cur_seq   = '0;
    endtask

    function automatic out_t frame_result(input logic [1:0] k, input logic [31:0] body,
                                          input logic [1:0] code, input logic last);
        out_t r;
        r.out_kind       = k;
        r.body_word      = body;
        r.frame_type     = cur_type;
        r.frame_sequence = cur_seq;
        r.frame_bytes    = cur_len & FB_MASK;
        r.fault_code     = code;
        r.last_body      = last;
        return r;
    endfunction

    // Advance the deframer by one accepted request; queue the result it causes.
    task automatic advance_deframer(input in_t it);
        logic [31:0] w;
        out_t        r;
        logic        emits;
        logic        fails;
        logic [1:0]  code;
        w     = it.word;
        emits = 1'b0;
        fails = 1'b0;
        code  = ERR_NONE;
        r     = '0;
        if (it.kind == KIND_RESTART)
        begin
            stuck        = 1'b0;
            seq_expected = init_seq;
            clear_frame();
        end
        else if (!stuck)
        begin
            case (ph)
                PH_LEN:
                begin
                    cur_len = w[23:0];
                    if (w == 32'd0 || w[31] || w[1:0] != 2'd0 ||
                        (max_bytes != '0 && w > 32'(max_bytes)) ||
                        w >= (32'd1 << LENGTH_BITS) ||
                        (w != LEN_PAD && w < LEN_MIN))
                    begin
                        fails = 1'b1;
                        code  = ERR_LENGTH;
                    end
                    else if (w == LEN_PAD)
                    begin
                        clear_frame();
                    end
                    else
                    begin
                        crc_acc   = crc32_fold(CRC_PRESET, w);
                        body_left = WL_BITS'((w - LEN_MIN) >> 2);
                        ph        = PH_SEQ;
                    end
                end
                PH_SEQ:
                begin
                    cur_seq = w;
                    crc_acc = crc32_fold(crc_acc, w);
                    ph      = PH_TYPE;
                end
                PH_TYPE:
                begin
                    cur_type = w;
                    crc_acc  = crc32_fold(crc_acc, w);
                    ph       = (body_left != '0) ? PH_BODY : PH_CRC;
                end
                PH_BODY:
                begin
                    crc_acc   = crc32_fold(crc_acc, w);
                    body_left = body_left - 1'b1;
                    r         = frame_result(OUT_BODY, w, ERR_NONE, body_left == '0);
                    emits     = 1'b1;
                    if (body_left == '0)
                        ph = PH_CRC;
                end
                default:
                begin
                    if (crc_on && ~crc_acc != w)
                    begin
                        fails = 1'b1;
                        code  = ERR_CRC;
                    end
                    else if (cur_seq != seq_expected)
                    begin
                        fails = 1'b1;
                        code  = ERR_SEQUENCE;
                    end
                    else
                    begin
                        seq_expected = seq_expected + 32'd1;
                        r            = frame_result(OUT_GOOD, 32'd0, ERR_NONE, 1'b0);
                        emits        = 1'b1;
                        clear_frame();
                    end
                end
            endcase
            if (fails)
            begin
                r     = frame_result(OUT_ERROR, 32'd0, code, 1'b0);
                emits = 1'b1;
                stuck = 1'b1;
                clear_frame();
            end
        end
        if (emits)
            pending_results.push_back(r);
    endtask

    function automatic int diff_field(input string name, input logic [31:0] e,
                                      input logic [31:0] a);
        if (e !== a)
        begin
            $error("%s: expected %h, got %h", name, e, a);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_t e;
        int   n;
        if (!rst_n)
        begin
            max_bytes    = '0;
            crc_on       = 1'b1;
            init_seq     = INIT_SEQ_RESET;
            seq_expected = INIT_SEQ_RESET;
            stuck        = 1'b0;
            clear_frame();
            pending_results.delete();
            bad_count    = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // Compare the popped result against the oldest prediction
            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result: none expected, got kind %h", result.out_kind);
                    bad_count++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    n = 0;
                    n += diff_field("out_kind", 32'(e.out_kind), 32'(result.out_kind));
                    n += diff_field("body_word", e.body_word, result.body_word);
                    n += diff_field("frame_type", e.frame_type, result.frame_type);
                    n += diff_field("frame_sequence", e.frame_sequence, result.frame_sequence);
                    n += diff_field("frame_bytes", 32'(e.frame_bytes), 32'(result.frame_bytes));
                    n += diff_field("fault_code", 32'(e.fault_code), 32'(result.fault_code));
                    n += diff_field("last_body", 32'(e.last_body), 32'(result.last_body));
                    if (n != 0)
                        bad_count++;
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_MAX_FRAME_BYTES:  max_bytes = cfg_data[23:0];
                    CFG_CRC_CHECK_ENABLE: crc_on    = cfg_data[0];
                    CFG_INITIAL_SEQUENCE: init_seq  = cfg_data;
                    default: ;
                endcase
            end
            if (push && !full)
                advance_deframer(item);
            mismatches  <= bad_count;
            outstanding <= pending_results.size();
        end
    end

endmodule

// File: test/testbench.sv
// Top of the deframer testbench: clock, reset, request stimulus and the verdict.
module testbench;
    import rfcd_pkg::*;
    import frame_crc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int IDLE_PCT      = 38;
    localparam int PHASE_WORDS   = 95;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    logic        full;
    in_t         item      = '0;
    logic        empty;
    logic        pop       = 1'b0;
    out_t        result;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = CFG_MAX_FRAME_BYTES;
    logic [31:0] cfg_data  = '0;

    int mismatches;
    int outstanding;

    // Shared pacing controls: steady turns idling off on both sides, and each
    // bump of hold_ask makes the receiver hold off for a long stretch.
    logic steady   = 1'b0;
    int   hold_ask = 0;
    int   hold_seen = 0;
    int   cycles   = 0;

    // Stimulus-side view of the registers and of the next good sequence number
    logic [23:0] cur_max;
    logic        cur_crc_en;
    logic [31:0] cur_init;
    logic [31:0] next_seq;
    int          words_sent = 0;

    rpc_frame_crc_deframer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frame_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .item        (item),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Cycle limit: end the run if the stimulus or the drain hangs.
    initial
    begin
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: pop at random, or always when steady, or hold off completely when asked.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_ask != hold_seen)
            begin
                hold_seen = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Offer one request and hold it until the block takes it; then idle at random.
    // Push is left high when no idle follows, so back-to-back requests never
    // drop and raise it in the same step.
    task automatic send_item(input logic k, input logic [31:0] w);
        in_t it;
        it.kind = k;
        it.word = w;
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        words_sent++;
        if (!steady)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    // Restart: reload the sequence and clear the failed state.
    task automatic restart();
        send_item(KIND_RESTART, $urandom);
        next_seq = cur_init;
    endtask

    // Stop offering, wait until every predicted result has been popped, then
    // let requests that cause no result drain out of the block.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three registers back to back; call only while the block is idle.
    task automatic write_regs(input logic [23:0] mx, input logic en, input logic [31:0] init);
        cfg_write <= 1'b1;
        cfg_index <= CFG_MAX_FRAME_BYTES;
        cfg_data  <= 32'(mx);
        @(posedge clk);
        cfg_index <= CFG_CRC_CHECK_ENABLE;
        cfg_data  <= 32'(en);
        @(posedge clk);
        cfg_index <= CFG_INITIAL_SEQUENCE;
        cfg_data  <= init;
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_max    = mx;
        cur_crc_en = en;
        cur_init   = init;
    endtask

    // Send one frame of nbody body words. seq_off skews the sequence number and
    // crc_flip corrupts the CRC word; a broken frame is followed by a restart.
    // A frame longer than the limit stops at its length word; a dropped word follows.
    task automatic try_frame(input int nbody, input logic [31:0] seq_off,
                             input logic [31:0] crc_flip, input logic [31:0] typ);
        logic [31:0] len_w;
        logic [31:0] crc;
        logic [31:0] w;
        len_w = LEN_MIN + 32'(nbody) * 32'd4;
        if (cur_max != '0 && len_w > 32'(cur_max))
        begin
            send_item(KIND_WORD, len_w);
            send_item(KIND_WORD, $urandom);
            restart();
        end
        else
        begin
            crc = crc32_fold(CRC_PRESET, len_w);
            send_item(KIND_WORD, len_w);
            w   = next_seq + seq_off;
            crc = crc32_fold(crc, w);
            send_item(KIND_WORD, w);
            crc = crc32_fold(crc, typ);
            send_item(KIND_WORD, typ);
            repeat (nbody)
            begin
                w   = $urandom;
                crc = crc32_fold(crc, w);
                send_item(KIND_WORD, w);
            end
            send_item(KIND_WORD, ~crc ^ crc_flip);
            if (seq_off == 32'd0 && (crc_flip == 32'd0 || !cur_crc_en))
                next_seq = next_seq + 32'd1;
            else
                restart();
        end
    endtask

    // A rejected length word, one word that the failed block must drop, a restart.
    task automatic bad_length(input logic [31:0] len_w);
        send_item(KIND_WORD, len_w);
        send_item(KIND_WORD, $urandom);
        restart();
    endtask

    // One random chunk of stimulus: mostly well-formed frames with random
    // content, the rest padding, broken frames, bad lengths and noise.
    task automatic random_item();
        int          pick;
        int          nbody;
        int          fit;
        logic [31:0] flip;
        pick  = $urandom_range(99);
        nbody = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(6);
        // Keep most frames inside the length limit
        if (cur_max >= 24'd16 && $urandom_range(4) != 0)
        begin
            fit = (cur_max - 24'd16) / 4;
            if (nbody > fit)
                nbody = $urandom_range(fit);
        end
        flip = $urandom;
        if (flip == 32'd0)
            flip = 32'd1;
        if (pick < 70)
            try_frame(nbody, 32'd0, cur_crc_en ? 32'd0 : (($urandom_range(1) != 0) ? flip : 32'd0),
                      $urandom);
        else if (pick < 76)
        begin
            send_item(KIND_WORD, LEN_PAD);
            if (cur_max != '0 && cur_max < 24'd4)
                restart();
        end
        else if (pick < 82)
            try_frame(nbody, 32'd0, flip, $urandom);
        else if (pick < 87)
            try_frame(nbody, flip, ($urandom_range(3) == 0) ? flip : 32'd0, $urandom);
        else if (pick < 92)
        begin
            case ($urandom_range(6))
                0: bad_length(32'd0);
                1: bad_length($urandom | 32'h8000_0000);
                2: bad_length(($urandom & 32'h00FF_FFFC) | 32'($urandom_range(1, 3)));
                3: bad_length(($urandom_range(1) != 0) ? 32'd8 : 32'd12);
                4: bad_length(32'h0100_0000 + 32'd4 * 32'($urandom_range(1000)));
                5: bad_length((cur_max == '0 || cur_max >= 24'hFFFFFD) ? 32'h0100_0000 :
                              ((32'(cur_max) & ~32'd3) + 32'd4));
                default: bad_length(32'hFFFF_FFFC);
            endcase
        end
        else if (pick < 96)
        begin
            // Drop a partial frame with a restart part way through
            send_item(KIND_WORD, LEN_MIN + 32'(nbody) * 32'd4);
            repeat ($urandom_range(1, 2 + nbody)) send_item(KIND_WORD, $urandom);
            restart();
        end
        else
        begin
            send_item(KIND_WORD, $urandom);
            restart();
        end
    endtask

    // Main stimulus
    initial
    begin
        logic [23:0] mx;
        logic        en;
        logic [31:0] init;
        int          goal;
        cur_max    = '0;
        cur_crc_en = 1'b1;
        cur_init   = INIT_SEQ_RESET;
        next_seq   = INIT_SEQ_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, no length limit, CRC checked
        try_frame(0, 32'd0, 32'd0, 32'hFFFF_FFFF);          // empty body
        send_item(KIND_WORD, LEN_PAD);                      // padding frame
        try_frame(2, 32'd0, 32'd0, 32'd0);                  // sequence -1, body words
        try_frame(1, 32'd0, 32'd1, $urandom);               // CRC mismatch
        try_frame(1, 32'd5, 32'd0, $urandom);               // sequence mismatch
        try_frame(0, 32'd1, 32'h8000_0000, $urandom);       // CRC wins over sequence
        bad_length(32'd0);
        bad_length(32'h8000_0000);
        bad_length(32'hFFFF_FFFC);
        bad_length(32'd6);
        bad_length(32'd8);
        bad_length(32'd12);
        bad_length(32'h0100_0000);
        // Restart part way into a frame, then a clean frame
        send_item(KIND_WORD, 32'd20);
        send_item(KIND_WORD, next_seq);
        restart();
        try_frame(1, 32'd0, 32'd0, $urandom);
        restart();

        // Limit of 32 bytes, CRC ignored; the new initial sequence waits for a restart
        drain();
        write_regs(24'd32, 1'b0, 32'h7FFF_FFFF);
        try_frame(0, 32'd0, $urandom | 32'd1, $urandom);    // old sequence still expected
        restart();
        try_frame(5, 32'd0, 32'd0, $urandom);               // 36 bytes, over the limit
        try_frame(4, 32'd0, $urandom | 32'd1, $urandom);    // exactly at the limit
        try_frame(0, 32'd0, 32'd0, $urandom);               // sequence wraps to the minimum

        // Back pressure: hold the receiver off while long frames keep coming,
        // then pause until every result is out
        drain();
        write_regs(24'd0, 1'b1, $urandom);
        restart();
        hold_ask <= hold_ask + 1;
        repeat (4) try_frame(24, 32'd0, 32'd0, $urandom);
        drain();

        // Random phases, each under its own register setting
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    mx = 24'd0;       en = 1'b1; init = $urandom;
                end
                1:
                begin
                    mx = 24'hFFFFFF;  en = 1'b0; init = 32'h8000_0000;
                end
                2:
                begin
                    mx = 24'd16;      en = 1'b1; init = 32'h7FFF_FFFF;
                end
                3:
                begin
                    mx = 24'd16 + 24'd4 * 24'($urandom_range(40));
                    en = $urandom_range(1);
                    init = $urandom;
                end
                4:
                begin
                    mx = 24'($urandom_range(24'hFFFFFF)); en = 1'b1; init = 32'hFFFF_FFFF;
                end
                default:
                begin
                    mx = 24'd0;       en = 1'b1; init = INIT_SEQ_RESET;
                end
            endcase
            drain();
            write_regs(mx, en, init);
            restart();
            // Run the first phase without any idling on either side
            if (p == 0)
                steady <= 1'b1;
            else if (p == 1)
                steady <= 1'b0;
            goal = words_sent + PHASE_WORDS;
            while (words_sent < goal)
                random_item();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
